// ===== src/mrs_pkg.sv =====
// Shared types, codes and widths of the minimal residual solver.
`timescale 1ns / 1ps
`default_nettype none
package mrs_pkg;

   localparam int MRS_MAX_N     = 64;
   localparam int MRS_FRAC_BITS = 16;

   localparam int DATA_W = 32;
   localparam int ACC_W  = 64;
   localparam int TOL_W  = 40;
   localparam int ITER_W = 16;

   // Input item codes
   localparam logic [1:0] FUNC_MATRIX = 2'd0;
   localparam logic [1:0] FUNC_RHS    = 2'd1;
   localparam logic [1:0] FUNC_SOLVE  = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_ROWS  = 2'd0;
   localparam logic [1:0] CSR_TOL   = 2'd1;
   localparam logic [1:0] CSR_LIMIT = 2'd2;

   // Stop codes
   localparam logic [1:0] STAT_CONV  = 2'd0;
   localparam logic [1:0] STAT_LIMIT = 2'd1;
   localparam logic [1:0] STAT_ZERO  = 2'd2;

   // Control of the shared multiply-accumulate unit
   typedef struct packed {
      logic mul_en;
      logic uns;
   } mac_ctl_type;

endpackage
`default_nettype wire

// ===== src/mrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mrs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== src/mrs_mac.sv =====
// Shared multiplier with registered product and saturating accumulate adder.
`timescale 1ns / 1ps
`default_nettype none
module mrs_mac import mrs_pkg::*; (
   input  wire logic                     clock,
   input  wire mac_ctl_type              ctl,
   input  wire logic signed [DATA_W-1:0] op_a,
   input  wire logic signed [DATA_W-1:0] op_b,
   input  wire logic        [ACC_W-1:0]  acc_in,
   output logic signed      [ACC_W-1:0]  prod,
   output logic             [ACC_W-1:0]  sum
);

   logic signed [ACC_W-1:0] mul_w;
   logic signed [ACC_W-1:0] prod_ff;
   logic        [ACC_W:0]   s_sum;
   logic        [ACC_W:0]   u_sum;

   assign mul_w = op_a * op_b;

   // Register the product
   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= mul_w;
      end
   end

   assign prod  = prod_ff;
   assign s_sum = {acc_in[ACC_W-1], acc_in} + {prod_ff[ACC_W-1], prod_ff};
   assign u_sum = {1'b0, acc_in} + {1'b0, prod_ff};

   // Saturate signed or unsigned
   always_comb begin
      if (ctl.uns) begin
         sum = u_sum[ACC_W] ? {ACC_W{1'b1}} : u_sum[ACC_W-1:0];
      end else if (s_sum[ACC_W] != s_sum[ACC_W-1]) begin
         sum = s_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         sum = s_sum[ACC_W-1:0];
      end
   end

endmodule
`default_nettype wire

// ===== src/mrs_div.sv =====
// Restoring divider for the step length tau, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mrs_div import mrs_pkg::*; #(
   parameter int FRAC_BITS = MRS_FRAC_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [ACC_W-1:0]  num,
   input  wire logic        [ACC_W-1:0]  den,
   output logic                          done,
   output logic signed      [DATA_W-1:0] tau
);

   localparam int DW = ACC_W + DATA_W - 1;

   logic          busy_ff;
   logic          done_ff;
   logic          neg_ff;
   logic [4:0]    k_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] ds_ff;
   logic [30:0]   q_ff;
   logic [DATA_W-1:0] tau_ff;
   logic [ACC_W-1:0]  mag;
   logic          ge;
   logic [30:0]   q_new;
   logic [DATA_W-1:0] res;

   assign mag   = num[ACC_W-1] ? (~num + 1'b1) : num;
   assign ge    = rem_ff >= ds_ff;
   assign q_new = {q_ff[29:0], ge};
   assign res   = (k_ff == 5'd31) ? {1'b0, {31{1'b1}}} : {1'b0, q_new};

   // Step through the quotient bits, top one as saturation test
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            neg_ff  <= num[ACC_W-1];
            rem_ff  <= DW'(mag) << FRAC_BITS;
            ds_ff   <= DW'(den) << 31;
            k_ff    <= 5'd31;
            q_ff    <= '0;
         end else if (busy_ff) begin
            if ((k_ff == 5'd31 && ge) || k_ff == 5'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               tau_ff  <= neg_ff ? (~res + 1'b1) : res;
            end else begin
               if (k_ff != 5'd31) begin
                  q_ff <= q_new;
               end
               if (ge) begin
                  rem_ff <= rem_ff - ds_ff;
               end
               ds_ff <= ds_ff >> 1;
               k_ff  <= k_ff - 5'd1;
            end
         end
      end
   end

   assign done = done_ff;
   assign tau  = tau_ff;

endmodule
`default_nettype wire

// ===== src/minimal_residual_solver.sv =====
// Top level: sequencer, stores and result port of the minimal residual solver.
// A solve clears x and forms |b|^2, builds the stop bound, then runs passes on one shared
// multiply-accumulate unit and the divider (which stops early when tau saturates), then
// sends out the solution elements one at a time.
// req_stall stays high from solve acceptance until the last element enters the result register.
// Synchronous reset clears control and registers; stores are not cleared, x at solve start.
`timescale 1ns / 1ps
`default_nettype none
module minimal_residual_solver import mrs_pkg::*; #(
   parameter int MAX_N     = MRS_MAX_N,
   parameter int FRAC_BITS = MRS_FRAC_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_func,
   input  wire logic [5:0]               req_row,
   input  wire logic [5:0]               req_col,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [5:0]                    rsp_index,
   output logic signed [DATA_W-1:0]      rsp_x_value,
   output logic                          rsp_last,
   output logic [1:0]                    rsp_status,
   output logic [ITER_W-1:0]             rsp_iterations,
   input  wire logic                     csr_write,
   input  wire logic [1:0]               csr_index,
   input  wire logic [TOL_W-1:0]         csr_data
);

   localparam int IW  = $clog2(MAX_N);
   localparam int MAW = $clog2(MAX_N * MAX_N);
   localparam int BW  = TOL_W + ACC_W;

   typedef enum logic [3:0] {
      S_IDLE, S_CLR, S_BOUND, S_CHECK, S_RES, S_PRD, S_DOT, S_DIV, S_UPD, S_OUT
   } state_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'({1'b0, {(DATA_W-1){1'b1}}});
      lo = -hi - 1;
      if (v > hi) begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v < lo) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         return v[DATA_W-1:0];
      end
   endfunction

   state_type         state_ff;
   logic [2:0]        ph_ff;
   logic [IW-1:0]     i_ff;
   logic [IW-1:0]     j_ff;
   logic [IW-1:0]     nm1_ff;
   logic [5:0]        k_ff;
   logic [6:0]        rows_ff;
   logic [TOL_W-1:0]  tol_ff;
   logic [ITER_W-1:0] limit_ff;
   logic [ITER_W-1:0] iter_ff;
   logic [1:0]        status_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]  num_ff;
   logic [ACC_W-1:0]  den_ff;
   logic [ACC_W-1:0]  r2_ff;
   logic [ACC_W-1:0]  bnorm_ff;
   logic [BW-1:0]     bound_ff;
   logic signed [DATA_W-1:0] tau_ff;
   logic              rsp_valid_ff;
   logic [5:0]        rsp_index_ff;
   logic [DATA_W-1:0] rsp_x_ff;
   logic              rsp_last_ff;
   logic [1:0]        rsp_status_ff;
   logic [ITER_W-1:0] rsp_iter_ff;

   logic              i_last;
   logic              j_last;
   logic              req_take;
   int                n_int;

   logic signed [DATA_W-1:0] mat_q;
   logic signed [DATA_W-1:0] rhs_q;
   logic signed [DATA_W-1:0] x_q;
   logic signed [DATA_W-1:0] r_q;
   logic signed [DATA_W-1:0] p_q;
   logic              mat_we;
   logic              rhs_we;
   logic              x_we;
   logic              r_we;
   logic              p_we;
   logic [MAW-1:0]    mat_waddr;
   logic [MAW-1:0]    mat_raddr;
   logic [IW-1:0]     x_raddr;
   logic [IW-1:0]     r_raddr;
   logic [DATA_W-1:0] x_wdata;
   logic [DATA_W-1:0] r_wdata;
   logic [DATA_W-1:0] p_wdata;

   mac_ctl_type              mac_ctl;
   logic signed [DATA_W-1:0] mac_a;
   logic signed [DATA_W-1:0] mac_b;
   logic [ACC_W-1:0]         mac_acc;
   logic signed [ACC_W-1:0]  mac_prod;
   logic [ACC_W-1:0]         mac_sum;
   logic signed [ACC_W-1:0]  sum_shr;

   logic              div_start;
   logic              div_done;
   logic signed [DATA_W-1:0] div_tau;

   assign i_last    = i_ff == nm1_ff;
   assign j_last    = j_ff == nm1_ff;
   assign req_stall = state_ff != S_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign sum_shr   = signed'(mac_sum) >>> FRAC_BITS;

   // Clamp the system order
   always_comb begin
      if (rows_ff == 7'd0) begin
         n_int = 1;
      end else if (int'(rows_ff) > MAX_N) begin
         n_int = MAX_N;
      end else begin
         n_int = int'(rows_ff);
      end
   end

   // Store ports
   assign mat_we    = req_take && req_func == FUNC_MATRIX &&
                      int'(req_row) < MAX_N && int'(req_col) < MAX_N;
   assign rhs_we    = req_take && req_func == FUNC_RHS && int'(req_row) < MAX_N;
   assign mat_waddr = MAW'(int'(req_row) * MAX_N + int'(req_col));
   assign mat_raddr = MAW'(int'(i_ff) * MAX_N + int'(j_ff));
   assign x_raddr   = (state_ff == S_RES) ? j_ff : i_ff;
   assign r_raddr   = (state_ff == S_PRD) ? j_ff : i_ff;
   assign x_we      = (state_ff == S_CLR && ph_ff == 3'd0) ||
                      (state_ff == S_UPD && ph_ff == 3'd2);
   assign x_wdata   = (state_ff == S_CLR) ? '0 : sat32(ACC_W'(x_q) - (mac_prod >>> FRAC_BITS));
   assign r_we      = state_ff == S_RES && ph_ff == 3'd2 && j_last;
   assign r_wdata   = sat32(sum_shr - ACC_W'(rhs_q));
   assign p_we      = state_ff == S_PRD && ph_ff == 3'd2 && j_last;
   assign p_wdata   = sat32(sum_shr);
   assign div_start = state_ff == S_DOT && ph_ff == 3'd4 && i_last && den_ff != '0;

   // Steer the shared unit
   always_comb begin
      mac_ctl = '0;
      mac_a   = r_q;
      mac_b   = r_q;
      mac_acc = acc_ff;
      case (state_ff)
         S_CLR: begin
            mac_ctl.mul_en = ph_ff == 3'd1;
            mac_ctl.uns    = 1'b1;
            mac_a          = rhs_q;
            mac_b          = rhs_q;
            mac_acc        = bnorm_ff;
         end
         S_RES: begin
            mac_ctl.mul_en = ph_ff == 3'd1;
            mac_a          = mat_q;
            mac_b          = x_q;
         end
         S_PRD: begin
            mac_ctl.mul_en = ph_ff == 3'd1;
            mac_a          = mat_q;
            mac_b          = r_q;
         end
         S_DOT: begin
            mac_ctl.mul_en = ph_ff == 3'd1 || ph_ff == 3'd2 || ph_ff == 3'd3;
            if (ph_ff == 3'd1) begin
               mac_b = p_q;
            end else if (ph_ff == 3'd2) begin
               mac_a = p_q;
               mac_b = p_q;
            end
            if (ph_ff == 3'd2) begin
               mac_acc = num_ff;
            end else if (ph_ff == 3'd3) begin
               mac_acc = den_ff;
            end else begin
               mac_acc     = r2_ff;
               mac_ctl.uns = 1'b1;
            end
         end
         S_UPD: begin
            mac_ctl.mul_en = ph_ff == 3'd1;
            mac_a          = tau_ff;
         end
         default: begin
            mac_ctl = '0;
         end
      endcase
   end

   // Sequencer, accumulators, registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ph_ff        <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         rows_ff      <= 7'd64;
         tol_ff       <= TOL_W'(1);
         limit_ff     <= ITER_W'(10000);
         iter_ff      <= '0;
         status_ff    <= STAT_LIMIT;
         bnorm_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ROWS:  rows_ff  <= csr_data[6:0];
               CSR_TOL:   tol_ff   <= csr_data;
               CSR_LIMIT: limit_ff <= csr_data[ITER_W-1:0];
               default:   ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take && req_func == FUNC_SOLVE) begin
                  nm1_ff    <= IW'(n_int - 1);
                  i_ff      <= '0;
                  ph_ff     <= '0;
                  iter_ff   <= '0;
                  bnorm_ff  <= '0;
                  status_ff <= STAT_LIMIT;
                  state_ff  <= S_CLR;
               end
            end
            S_CLR: begin
               ph_ff <= ph_ff + 3'd1;
               if (ph_ff == 3'd2) begin
                  bnorm_ff <= mac_sum;
                  ph_ff    <= '0;
                  i_ff     <= i_ff + 1'b1;
                  if (i_last) begin
                     k_ff     <= '0;
                     bound_ff <= '0;
                     state_ff <= S_BOUND;
                  end
               end
            end
            S_BOUND: begin
               if (tol_ff[k_ff]) begin
                  bound_ff <= bound_ff + (BW'(bnorm_ff) << k_ff);
               end
               k_ff <= k_ff + 6'd1;
               if (k_ff == 6'(TOL_W - 1)) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               i_ff   <= '0;
               j_ff   <= '0;
               ph_ff  <= '0;
               acc_ff <= '0;
               if (iter_ff >= limit_ff) begin
                  status_ff <= STAT_LIMIT;
                  state_ff  <= S_OUT;
               end else begin
                  state_ff <= S_RES;
               end
            end
            S_RES, S_PRD: begin
               ph_ff <= ph_ff + 3'd1;
               if (ph_ff == 3'd2) begin
                  ph_ff <= '0;
                  if (j_last) begin
                     acc_ff <= '0;
                     j_ff   <= '0;
                     i_ff   <= i_last ? '0 : i_ff + 1'b1;
                     if (i_last) begin
                        num_ff   <= '0;
                        den_ff   <= '0;
                        r2_ff    <= '0;
                        state_ff <= (state_ff == S_RES) ? S_PRD : S_DOT;
                     end
                  end else begin
                     acc_ff <= mac_sum;
                     j_ff   <= j_ff + 1'b1;
                  end
               end
            end
            S_DOT: begin
               ph_ff <= ph_ff + 3'd1;
               if (ph_ff == 3'd2) begin
                  num_ff <= mac_sum;
               end else if (ph_ff == 3'd3) begin
                  den_ff <= mac_sum;
               end else if (ph_ff == 3'd4) begin
                  r2_ff <= mac_sum;
                  ph_ff <= '0;
                  i_ff  <= i_last ? '0 : i_ff + 1'b1;
                  if (i_last) begin
                     if (den_ff == '0) begin
                        status_ff <= STAT_ZERO;
                        state_ff  <= S_OUT;
                     end else begin
                        state_ff <= S_DIV;
                     end
                  end
               end
            end
            S_DIV: begin
               if (div_done) begin
                  tau_ff   <= div_tau;
                  state_ff <= S_UPD;
               end
            end
            S_UPD: begin
               ph_ff <= ph_ff + 3'd1;
               if (ph_ff == 3'd2) begin
                  ph_ff <= '0;
                  i_ff  <= i_last ? '0 : i_ff + 1'b1;
                  if (i_last) begin
                     iter_ff <= iter_ff + 1'b1;
                     if ({r2_ff, {TOL_W{1'b0}}} < bound_ff) begin
                        status_ff <= STAT_CONV;
                        state_ff  <= S_OUT;
                     end else begin
                        state_ff <= S_CHECK;
                     end
                  end
               end
            end
            S_OUT: begin
               if (ph_ff == 3'd0) begin
                  ph_ff <= 3'd1;
               end else if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_index_ff  <= 6'(i_ff);
                  rsp_x_ff      <= x_q;
                  rsp_last_ff   <= i_last;
                  rsp_status_ff <= status_ff;
                  rsp_iter_ff   <= iter_ff;
                  ph_ff         <= '0;
                  i_ff          <= i_ff + 1'b1;
                  if (i_last) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_index      = rsp_index_ff;
   assign rsp_x_value    = rsp_x_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_iterations = rsp_iter_ff;

   mrs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_N * MAX_N)) u_mat (
      .clock(clock), .wr_en(mat_we), .wr_addr(mat_waddr), .wr_data(req_value),
      .rd_addr(mat_raddr), .rd_data(mat_q)
   );

   mrs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_N)) u_rhs (
      .clock(clock), .wr_en(rhs_we), .wr_addr(IW'(req_row)), .wr_data(req_value),
      .rd_addr(i_ff), .rd_data(rhs_q)
   );

   mrs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_N)) u_x (
      .clock(clock), .wr_en(x_we), .wr_addr(i_ff), .wr_data(x_wdata),
      .rd_addr(x_raddr), .rd_data(x_q)
   );

   mrs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_N)) u_r (
      .clock(clock), .wr_en(r_we), .wr_addr(i_ff), .wr_data(r_wdata),
      .rd_addr(r_raddr), .rd_data(r_q)
   );

   mrs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_N)) u_p (
      .clock(clock), .wr_en(p_we), .wr_addr(i_ff), .wr_data(p_wdata),
      .rd_addr(i_ff), .rd_data(p_q)
   );

   mrs_mac u_mac (
      .clock(clock), .ctl(mac_ctl), .op_a(mac_a), .op_b(mac_b),
      .acc_in(mac_acc), .prod(mac_prod), .sum(mac_sum)
   );

   mrs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(num_ff),
      .den(den_ff), .done(div_done), .tau(div_tau)
   );

   // Outside the output phase only the final element of a solve may still wait
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && state_ff != S_OUT) |-> rsp_last_ff)
      else $error("non-final result pending outside output phase");

   // The last element carries the top index
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> rsp_index_ff == 6'(nm1_ff))
      else $error("last flag on wrong element");

   // Divider only answers while awaited
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside its phase");

   // Pass count never runs past the limit during a solve
   a_iter_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> iter_ff <= limit_ff)
      else $error("pass count beyond limit");

   // Leaving the update phase counts one pass
   a_iter_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD && ph_ff == 3'd2 && i_last) |=> iter_ff == $past(iter_ff) + 1'b1)
      else $error("pass not counted");

endmodule
`default_nettype wire

// ===== test/minimal_residual_solver_checker.sv =====
// Transaction monitor, solution predictor and result comparison for the solver.
`timescale 1ns / 1ps
module minimal_residual_solver_checker import mrs_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic [1:0]        req_func,
   input  wire logic [5:0]        req_row,
   input  wire logic [5:0]        req_col,
   input  wire logic [31:0]       req_value,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic [5:0]        rsp_index,
   input  wire logic [31:0]       rsp_x_value,
   input  wire logic              rsp_last,
   input  wire logic [1:0]        rsp_status,
   input  wire logic [ITER_W-1:0] rsp_iterations,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [TOL_W-1:0]  csr_data,
   output int                     fail_count,
   output int                     sol_pending,
   output int                     sol_predicted
);

   typedef struct packed {
      logic [5:0]        idx;
      logic [31:0]       xv;
      logic              last;
      logic [1:0]        stat;
      logic [ITER_W-1:0] iters;
   } sol_elem_type;

   sol_elem_type sol_queue[$];

   int mat_a[MRS_MAX_N][MRS_MAX_N];
   int vec_b[MRS_MAX_N];
   int vec_x[MRS_MAX_N];
   int vec_r[MRS_MAX_N];
   int vec_p[MRS_MAX_N];

   logic [6:0]        rows_cfg;
   logic [TOL_W-1:0]  tol_cfg;
   logic [ITER_W-1:0] limit_cfg;

   localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

   function automatic longint sadd(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
      return s;
   endfunction

   function automatic logic [63:0] usadd(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
   endfunction

   // tau = (num * 2^FRAC) / den, truncated toward zero and clamped
   function automatic int step_factor(longint num, longint den);
      logic [63:0]  mag;
      logic [63:0]  d;
      logic [127:0] w;
      logic [31:0]  res;
      mag = num[63] ? (64'd0 - num) : num;
      d = den;
      if (mag / d >= (64'd1 << (31 - MRS_FRAC_BITS))) begin
         res = 32'h7FFF_FFFF;
      end else begin
         w = {64'd0, mag} << MRS_FRAC_BITS;
         w = w / {64'd0, d};
         res = w[31:0];
      end
      return num[63] ? -int'(res) : int'(res);
   endfunction

   // Run one solve and queue the n solution elements
   function automatic void predict_solution();
      int          n;
      int unsigned passes;
      logic [1:0]  stat;
      longint      acc;
      longint      num;
      longint      den;
      longint      stp;
      int          tau;
      logic [63:0] r2;
      logic [63:0] bnorm;
      logic [127:0] lhs;
      logic [127:0] rhs;
      sol_elem_type e;
      n = rows_cfg;
      if (n < 1) n = 1;
      if (n > MRS_MAX_N) n = MRS_MAX_N;
      for (int i = 0; i < MRS_MAX_N; i++) vec_x[i] = 0;
      passes = 0;
      stat = STAT_LIMIT;
      bnorm = 0;
      for (int i = 0; i < n; i++)
         bnorm = usadd(bnorm, 64'(longint'(vec_b[i]) * vec_b[i]));
      while (passes < limit_cfg) begin
         for (int i = 0; i < n; i++) begin
            acc = 0;
            for (int j = 0; j < n; j++) acc = sadd(acc, longint'(mat_a[i][j]) * vec_x[j]);
            vec_r[i] = sat32((acc >>> MRS_FRAC_BITS) - vec_b[i]);
         end
         for (int i = 0; i < n; i++) begin
            acc = 0;
            for (int j = 0; j < n; j++) acc = sadd(acc, longint'(mat_a[i][j]) * vec_r[j]);
            vec_p[i] = sat32(acc >>> MRS_FRAC_BITS);
         end
         num = 0;
         den = 0;
         r2 = 0;
         for (int i = 0; i < n; i++) begin
            num = sadd(num, longint'(vec_r[i]) * vec_p[i]);
            den = sadd(den, longint'(vec_p[i]) * vec_p[i]);
            r2 = usadd(r2, 64'(longint'(vec_r[i]) * vec_r[i]));
         end
         if (den == 0) begin
            stat = STAT_ZERO;
            break;
         end
         tau = step_factor(num, den);
         for (int i = 0; i < n; i++) begin
            stp = (longint'(tau) * vec_r[i]) >>> MRS_FRAC_BITS;
            vec_x[i] = sat32(longint'(vec_x[i]) - stp);
         end
         passes = (passes + 1) & 16'hFFFF;
         // stop test on the pre-update residual
         lhs = {64'd0, r2} << 40;
         rhs = {88'd0, tol_cfg} * {64'd0, bnorm};
         if (lhs < rhs) begin
            stat = STAT_CONV;
            break;
         end
      end
      for (int i = 0; i < n; i++) begin
         e.idx = i[5:0];
         e.xv = vec_x[i];
         e.last = (i == n - 1);
         e.stat = stat;
         e.iters = passes[15:0];
         sol_queue.push_back(e);
      end
      sol_predicted += n;
   endfunction

   initial begin
      fail_count = 0;
      sol_pending = 0;
      sol_predicted = 0;
   end

   always @(posedge clock) begin
      sol_elem_type e;
      if (reset) begin
         rows_cfg <= 7'd64;
         tol_cfg <= 40'd1;
         limit_cfg <= 16'd10000;
         sol_queue.delete();
      end else begin
         // register writes
         if (csr_write) begin
            case (csr_index)
               CSR_ROWS: begin
                  rows_cfg <= csr_data[6:0];
               end
               CSR_TOL: begin
                  tol_cfg <= csr_data;
               end
               CSR_LIMIT: begin
                  limit_cfg <= csr_data[15:0];
               end
               default: begin
               end
            endcase
         end
         // input transactions
         if (req_valid && !req_stall) begin
            case (req_func)
               FUNC_MATRIX: begin
                  mat_a[req_row][req_col] = req_value;
               end
               FUNC_RHS: begin
                  vec_b[req_row] = req_value;
               end
               FUNC_SOLVE: begin
                  predict_solution();
               end
               default: begin
               end
            endcase
         end
         // result transactions
         if (rsp_valid && !rsp_stall) begin
            if (sol_queue.size() == 0) begin
               $display("%0t: unexpected result index %0d x %0d", $time, rsp_index,
                        $signed(rsp_x_value));
               fail_count++;
            end else begin
               e = sol_queue.pop_front();
               if (rsp_index !== e.idx || rsp_x_value !== e.xv || rsp_last !== e.last ||
                   rsp_status !== e.stat || rsp_iterations !== e.iters) begin
                  $display("%0t: mismatch expected idx %0d x %0d last %0d stat %0d iter %0d",
                           $time, e.idx, $signed(e.xv), e.last, e.stat, e.iters);
                  $display("%0t:          actual   idx %0d x %0d last %0d stat %0d iter %0d",
                           $time, rsp_index, $signed(rsp_x_value), rsp_last, rsp_status,
                           rsp_iterations);
                  fail_count++;
               end
            end
         end
      end
      sol_pending = sol_queue.size();
   end

endmodule

// ===== test/tb_minimal_residual_solver.sv =====
// Stimulus, handshake pacing and verdict for the minimal residual solver.
`timescale 1ns / 1ps
module tb_minimal_residual_solver import mrs_pkg::*;;

   // largest order used by the random rounds
   localparam int MAX_ORDER = 6;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_func;
   logic [5:0]        req_row;
   logic [5:0]        req_col;
   logic [31:0]       req_value;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [5:0]        rsp_index;
   logic [31:0]       rsp_x_value;
   logic              rsp_last;
   logic [1:0]        rsp_status;
   logic [ITER_W-1:0] rsp_iterations;
   logic              csr_write;
   logic [1:0]        csr_index;
   logic [TOL_W-1:0]  csr_data;
   int                fail_count;
   int                sol_pending;
   int                sol_predicted;
   bit                calm;
   int                sent;

   minimal_residual_solver dut (.*);

   minimal_residual_solver_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Send one transaction; called and returns at a falling edge
   task automatic send(input logic [1:0] f, input logic [5:0] r, input logic [5:0] c,
                       input logic [31:0] v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_row <= r;
      req_col <= c;
      req_value <= v;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent++;
   endtask

   // Drop valid and wait until all solution elements have arrived
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sol_pending != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [TOL_W-1:0] data);
      settle();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [31:0] small_val();
      return $urandom_range(0, 32767) - 16384;
   endfunction

   // Diagonally dominant system of order n with random content
   task automatic load_system(input int n);
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++)
            send(FUNC_MATRIX, i, j, (i == j) ? 32'h0004_0000 + small_val() : small_val());
         send(FUNC_RHS, i, 0, $urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
      end
   endtask

   // Output side stall pattern
   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         repeat ($urandom_range(0, 9) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 20))
            @(negedge clock);
         rsp_stall <= 1'b1;
         repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 3))
            @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      int n;
      int r;
      logic [TOL_W-1:0] tol;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_MATRIX;
      req_row = '0;
      req_col = '0;
      req_value = '0;
      csr_write = 1'b0;
      csr_index = CSR_ROWS;
      csr_data = '0;
      calm = 1'b0;
      sent = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill the corner that every later solve may read
      for (int i = 0; i < MAX_ORDER; i++) begin
         for (int j = 0; j < MAX_ORDER; j++)
            send(FUNC_MATRIX, i, j, (i * MAX_ORDER + j) % 16 == 0 ? $urandom :
                 (i == j ? 32'h0004_0000 + small_val() : small_val()));
         send(FUNC_RHS, i, 0, $urandom_range(0, 9) == 0 ? $urandom : small_val() * 8);
      end

      // order of zero clamps to one; no pass allowed
      write_reg(CSR_ROWS, 40'd0);
      write_reg(CSR_LIMIT, 40'd0);
      send(FUNC_SOLVE, 0, 0, 0);

      // zero matrix: zero divisor at first pass
      write_reg(CSR_LIMIT, 40'd65535);
      write_reg(CSR_TOL, 40'hFF_FFFF_FFFF);
      send(FUNC_MATRIX, 0, 0, 32'd0);
      send(FUNC_RHS, 0, 0, 32'h0001_0000);
      send(FUNC_SOLVE, 0, 0, 0);
      send(FUNC_MATRIX, 0, 0, 32'h0001_0000);
      send(FUNC_SOLVE, 0, 0, 0);
      // zero right-hand side
      send(FUNC_RHS, 0, 0, 32'd0);
      send(FUNC_SOLVE, 0, 0, 0);
      // extreme values saturate
      write_reg(CSR_LIMIT, 40'd3);
      send(FUNC_MATRIX, 0, 0, 32'h7FFF_FFFF);
      send(FUNC_RHS, 0, 0, 32'h8000_0000);
      send(FUNC_SOLVE, 0, 0, 0);
      send(FUNC_MATRIX, 0, 0, 32'h8000_0000);
      send(FUNC_RHS, 0, 0, 32'h7FFF_FFFF);
      send(FUNC_SOLVE, 0, 0, 0);
      // unknown code is ignored
      send(2'd3, 6'h3F, 6'h3F, 32'hFFFF_FFFF);
      // small well-formed system
      write_reg(CSR_ROWS, 40'd2);
      write_reg(CSR_TOL, 40'd1 << 20);
      write_reg(CSR_LIMIT, 40'd50);
      load_system(2);
      send(FUNC_SOLVE, 0, 0, 0);

      // random rounds of small systems
      while (sent < 130) begin
         calm = ($urandom_range(0, 4) == 0);
         n = $urandom_range(1, MAX_ORDER);
         r = $urandom_range(0, 3);
         tol = (r == 0) ? {$urandom, $urandom} : (r == 1) ? 40'd0 : $urandom_range(0, 1 << 22);
         write_reg(CSR_ROWS, n);
         write_reg(CSR_TOL, tol);
         write_reg(CSR_LIMIT, $urandom_range(0, 7) == 0 ? $urandom_range(26, 40) :
                   $urandom_range(1, 25));
         if ($urandom_range(0, 4) != 0) begin
            load_system(n);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 2) == 0)
                  send(2'd3, $urandom, $urandom, $urandom);
               else if ($urandom_range(0, 1) == 0)
                  send(FUNC_MATRIX, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                       $urandom);
               else
                  send(FUNC_RHS, $urandom_range(0, n - 1), $urandom, $urandom);
            end
         end
         send(FUNC_SOLVE, $urandom, $urandom, $urandom);
         if ($urandom_range(0, 5) == 0) send(FUNC_SOLVE, 0, 0, 0);
      end

      settle();
      repeat (50) @(negedge clock);
      if (fail_count == 0 && sol_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
